### hdl/tlxh_pkg.sv
`default_nettype none

package tlxh_pkg;

  // tag and replacement lengths
  localparam logic [3:0] TAG_LEN  = 4'd15;
  localparam logic [4:0] REPL_LEN = 5'd16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // special characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // body kinds of a command
  localparam logic [2:0] BODY_NONE  = 3'd0;
  localparam logic [2:0] BODY_CHAR  = 3'd1;
  localparam logic [2:0] BODY_REPL  = 3'd2;
  localparam logic [2:0] BODY_HEX   = 3'd3;
  localparam logic [2:0] BODY_CLOSE = 3'd4;

  // one classified input word: held tag bytes, a body, an optional error
  typedef struct packed {
    logic [3:0] flush_n;
    logic [2:0] body;
    logic [7:0] value;
    logic       err;
  } cmd_t;

  // tag text, closing quote included
  function automatic logic [7:0] tag_byte(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "M";
      4'd1:    ch = "U";
      4'd2:    ch = "E";
      4'd3:    ch = "N";
      4'd4:    ch = "C";
      4'd5:    ch = "O";
      4'd6:    ch = "D";
      4'd7:    ch = "E";
      4'd8:    ch = "S";
      4'd9:    ch = "T";
      4'd10:   ch = "R";
      4'd11:   ch = "I";
      4'd12:   ch = "N";
      4'd13:   ch = "G";
      4'd14:   ch = CH_QUOTE;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // replacement text
  function automatic logic [7:0] repl_byte(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = "M";
      4'd1:    ch = "U";
      4'd2:    ch = "D";
      4'd3:    ch = "E";
      4'd4:    ch = "C";
      4'd5:    ch = "O";
      4'd6:    ch = "D";
      4'd7:    ch = "E";
      4'd8:    ch = "S";
      4'd9:    ch = "T";
      4'd10:   ch = "R";
      4'd11:   ch = "I";
      4'd12:   ch = "N";
      4'd13:   ch = "G";
      4'd14:   ch = "(";
      default: ch = CH_QUOTE;
    endcase
    return ch;
  endfunction

  // upper-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] ch;
    if (v < 4'd10) begin
      ch = 8'h30 + {4'd0, v};
    end else begin
      ch = 8'h37 + {4'd0, v};
    end
    return ch;
  endfunction

  // simple escapes, zero for an unknown one
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] e;
    case (c)
      CH_QUOTE:  e = CH_QUOTE;
      8'h27:     e = 8'h27;
      8'h3F:     e = 8'h3F;
      CH_BSLASH: e = CH_BSLASH;
      "a":       e = 8'd7;
      "b":       e = 8'd8;
      "f":       e = 8'd12;
      "n":       e = 8'd10;
      "r":       e = 8'd13;
      "t":       e = 8'd9;
      "v":       e = 8'd11;
      default:   e = 8'd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

### hdl/tlxh_in_if.sv
`default_nettype none

interface tlxh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       stream_end;

  modport source (output valid, output in_char, output stream_end, input ready);
  modport sink (input valid, input in_char, input stream_end, output ready);
endinterface

`default_nettype wire

### hdl/tlxh_out_if.sv
`default_nettype none

interface tlxh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       error;
  logic       run_last;

  modport source (output valid, output out_char, output error, output run_last,
                  input ready);
  modport sink (input valid, input out_char, input error, input run_last,
                output ready);
endinterface

`default_nettype wire

### hdl/tlxh_front.sv
`default_nettype none

module tlxh_front
  import tlxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  tlxh_in_if.sink          rx,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        queue_full,
  output logic             push,
  output cmd_t             cmd
);

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_LIT  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [3:0]  match_cnt, match_cnt_next;
  logic [1:0]  mode, mode_next;
  logic [7:0]  lit_idx, lit_idx_next;

  logic        accept;
  logic [7:0]  c;
  logic        last;
  logic [7:0]  esc;
  logic [7:0]  src_byte;
  logic [7:0]  key_sel;
  logic [7:0]  enc;
  logic [127:0] key_all;

  assign rx.ready = !queue_full;
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.in_char;
  assign last     = rx.stream_end;
  assign esc      = map_escape(c);

  // key byte and encoded value for the current literal position
  assign key_all  = {key_high, key_low};
  assign key_sel  = key_all[{lit_idx[3:0], 3'b000} +: 8];
  assign src_byte = (mode == MODE_ESC) ? esc : c;
  assign enc      = src_byte ^ key_sel ^ lit_idx;

  // classify the word and work out the next scan state
  always_comb begin
    cmd            = '0;
    match_cnt_next = match_cnt;
    mode_next      = mode;
    lit_idx_next   = lit_idx;
    case (mode)
      MODE_COPY: begin
        if (match_cnt != TAG_LEN && c == tag_byte(match_cnt)) begin
          if (match_cnt == TAG_LEN - 4'd1) begin
            match_cnt_next = 4'd0;
            if (last) begin
              cmd.err   = 1'b1;
              mode_next = MODE_ERR;
            end else begin
              cmd.body     = BODY_REPL;
              mode_next    = MODE_LIT;
              lit_idx_next = 8'd0;
            end
          end else begin
            match_cnt_next = match_cnt + 4'd1;
            if (last) begin
              cmd.flush_n = match_cnt + 4'd1;
            end
          end
        end else begin
          cmd.flush_n = match_cnt;
          if (c == tag_byte(4'd0) && !last) begin
            match_cnt_next = 4'd1;
          end else begin
            match_cnt_next = 4'd0;
            cmd.body       = BODY_CHAR;
            cmd.value      = c;
          end
        end
      end
      MODE_LIT: begin
        if (c == CH_QUOTE) begin
          cmd.body  = BODY_CLOSE;
          mode_next = MODE_COPY;
        end else if (c == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else if (c == CH_NL) begin
          cmd.err   = 1'b1;
          mode_next = MODE_ERR;
        end else begin
          cmd.body     = BODY_HEX;
          cmd.value    = enc;
          lit_idx_next = lit_idx + 8'd1;
        end
      end
      MODE_ESC: begin
        if (esc == 8'd0) begin
          cmd.err   = 1'b1;
          mode_next = MODE_ERR;
        end else begin
          cmd.body     = BODY_HEX;
          cmd.value    = enc;
          lit_idx_next = lit_idx + 8'd1;
          mode_next    = MODE_LIT;
        end
      end
      default: begin
      end
    endcase
    // end of stream: unterminated literal check, then back to reset state
    if (last) begin
      if (mode_next == MODE_LIT || mode_next == MODE_ESC) begin
        cmd.err = 1'b1;
      end
      match_cnt_next = 4'd0;
      mode_next      = MODE_COPY;
      lit_idx_next   = 8'd0;
    end
  end

  assign push = accept && (cmd.flush_n != 4'd0 || cmd.body != BODY_NONE || cmd.err);

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_cnt <= 4'd0;
      mode      <= MODE_COPY;
      lit_idx   <= 8'd0;
    end else if (accept) begin
      match_cnt <= match_cnt_next;
      mode      <= mode_next;
      lit_idx   <= lit_idx_next;
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= 64'd0;
      key_high <= 64'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/tlxh_queue.sv
`default_nettype none

module tlxh_queue
  import tlxh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty,
  output logic      full
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == QUEUE_CW'(QUEUE_DEPTH);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tlxh_back.sv
`default_nettype none

module tlxh_back
  import tlxh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic not_empty,
  output logic      pop,
  tlxh_out_if.source tx
);

  logic [3:0] step;
  logic [4:0] body_len;
  logic [4:0] total;
  logic [3:0] body_pos;
  logic [7:0] ch;
  logic       ch_err;
  logic       ch_last;
  logic       load;

  // length of the body part
  always_comb begin
    case (head.body)
      BODY_CHAR:  body_len = 5'd1;
      BODY_REPL:  body_len = REPL_LEN;
      BODY_HEX:   body_len = 5'd2;
      BODY_CLOSE: body_len = 5'd2;
      default:    body_len = 5'd0;
    endcase
  end

  assign total    = {1'b0, head.flush_n} + body_len + {4'd0, head.err};
  assign body_pos = step - head.flush_n;
  assign ch_last  = ({1'b0, step} == total - 5'd1);

  // character at the current step: held tag, body, then error
  always_comb begin
    ch     = 8'd0;
    ch_err = 1'b0;
    if (step < head.flush_n) begin
      ch = tag_byte(step);
    end else if ({1'b0, body_pos} < body_len) begin
      case (head.body)
        BODY_CHAR:  ch = head.value;
        BODY_REPL:  ch = repl_byte(body_pos);
        BODY_HEX:   ch = (body_pos == 4'd0) ? hex_digit(head.value[7:4])
                                            : hex_digit(head.value[3:0]);
        BODY_CLOSE: ch = (body_pos == 4'd0) ? CH_QUOTE : CH_RPAREN;
        default:    ch = 8'd0;
      endcase
    end else begin
      ch_err = 1'b1;
    end
  end

  assign load = not_empty && (!tx.valid || tx.ready);
  assign pop  = load && ch_last;

  // step counter within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 4'd0;
    end else if (load) begin
      step <= ch_last ? 4'd0 : step + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (load) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx.out_char <= ch;
      tx.error    <= ch_err;
      tx.run_last <= ch_last;
    end
  end

endmodule

`default_nettype wire

### hdl/tagged_literal_xor_hex_rewriter.sv
`default_nettype none

// channel | dir | fields                      | accepted when
// rx      | in  | in_char, stream_end         | rx.valid && rx.ready
// tx      | out | out_char, error, run_last   | tx.valid && tx.ready
// cfg     | in  | cfg_index, cfg_data         | cfg_wr_en
//
// the front takes one source byte per cycle while its four-word queue has room;
// the back emits one character per cycle while a command waits and tx is ready;
// literal bytes yield two, a replacement sixteen, a partial tag up to fourteen.
// synchronous reset clears scan state, keys, queue and output valid.
// a stalled tx holds its word; the front keeps going until the queue fills.

module tagged_literal_xor_hex_rewriter
  import tlxh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  tlxh_in_if.sink          rx,
  tlxh_out_if.source       tx,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic not_empty;
  logic full;

  // classify and track tag / literal state
  tlxh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // command queue
  tlxh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  // expand commands into characters
  tlxh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .tx        (tx)
  );

endmodule

`default_nettype wire
